FILE: rtl/rgba_fir_pkg.sv
// ============================================================================
// rgba_fir_pkg
// Shared types for the RGBA line FIR filter: beat payloads, the register
// index codes and fixed field widths.
// ============================================================================
`default_nettype none

package rgba_fir_pkg;

   localparam int CHAN_W    = 8;
   localparam int NUM_CHANS = 4;
   localparam int PIXEL_W   = CHAN_W * NUM_CHANS;
   localparam int TAP_W     = 16;
   localparam int CSR_W     = 64;
   localparam int CSR_IDX_W = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TAP_COUNT = 2'd0,
      CSR_TAPS_LO   = 2'd1,
      CSR_TAPS_HI   = 2'd2,
      CSR_TAP_EIGHT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CHAN_W-1:0] in_chan_zero;
      logic [CHAN_W-1:0] in_chan_one;
      logic [CHAN_W-1:0] in_chan_two;
      logic [CHAN_W-1:0] in_chan_three;
      logic              in_line_end;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] out_chan_zero;
      logic [CHAN_W-1:0] out_chan_one;
      logic [CHAN_W-1:0] out_chan_two;
      logic [CHAN_W-1:0] out_chan_three;
      logic              out_line_end;
   } rsp_type;

endpackage

`default_nettype wire

FILE: rtl/rgba_fir_line_filter.sv
// ============================================================================
// rgba_fir_line_filter
// Four-channel FIR over one image line with clamp-to-edge borders, Q3.12
// taps, round-half-even and saturation to 0..255.
// ============================================================================
// Path: an accepted req beat is registered in the job stage, which then loads rsp (job then rsp).
// Throughput: one pixel per cycle while rsp_ready allows; a line-end beat with n
//   pending results keeps the result stage busy until all n are sent, with req_ready low until the last.
// The result stage computes one output pixel per cycle from a window copy while rsp is not stalled.
// Reset (synchronous): empties both stages, starts a new line and loads
//   the identity kernel (one tap of 1.0).
`default_nettype none

module rgba_fir_line_filter
   import rgba_fir_pkg::*;
#(
   parameter int MAX_TAPS      = 9,
   parameter int TAP_FRAC_BITS = 12
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_ready,
   input  wire req_type              req_data,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   output      rsp_type              rsp_data,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_data
);

   localparam int WinW  = PIXEL_W * MAX_TAPS;
   localparam int KW    = $clog2(MAX_TAPS + 1);
   localparam int CntW  = $clog2(MAX_TAPS / 2 + 2);
   localparam int SftW  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
   localparam int BaseW = ((KW > CntW) ? KW : CntW) + 1;
   localparam int ProdW = TAP_W + CHAN_W + 1;
   localparam int SumW  = ProdW + $clog2(MAX_TAPS + 1);
   localparam logic [TAP_FRAC_BITS-1:0] HalfUlp = TAP_FRAC_BITS'(1) << (TAP_FRAC_BITS - 1);
   localparam logic [WinW-1:0] LowMask = WinW'({PIXEL_W{1'b1}});

   // configuration
   logic [3:0]       tap_count_ff;
   logic [CSR_W-1:0] taps_lo_ff;
   logic [CSR_W-1:0] taps_hi_ff;
   logic [TAP_W-1:0] tap_eight_ff;

   // line state
   logic [WinW-1:0] window_ff, window_in;
   logic [CntW-1:0] lookahead_ff, lookahead_in;
   logic            at_line_start_ff, at_line_start_in;

   // result job: shifted window copy plus remaining result count
   logic            job_valid_ff, job_valid_in;
   logic [CntW-1:0] job_left_ff, job_left_in;
   logic            job_end_ff, job_end_in;
   logic [WinW-1:0] job_win_ff, job_win_in;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;

   logic [KW-1:0]          k_w;
   logic [KW-1:0]          half_w;
   logic [KW-1:0]          maxr_w;
   logic                   accept;
   logic                   out_load;
   logic                   job_done;
   logic [PIXEL_W-1:0]     px_word;
   logic [CntW-1:0]        look_new;
   logic                   emit_one;
   logic [BaseW-1:0]       base_w;
   logic [SftW-1:0]        shift_w;
   logic [WinW-1:0]        fill_win;
   logic [2*CSR_W+TAP_W-1:0] taps_flat;
   logic [TAP_W-1:0]       tap_arr [MAX_TAPS];
   logic [CHAN_W-1:0]      chan_res [NUM_CHANS];

   function automatic logic [CHAN_W-1:0] round_sat(input logic signed [SumW-1:0] s);
      logic signed [SumW-1:0]   fl;
      logic [TAP_FRAC_BITS-1:0] rem;
      logic                     up;
      logic signed [SumW-1:0]   r;
      fl  = s >>> TAP_FRAC_BITS;
      rem = s[TAP_FRAC_BITS-1:0];
      up  = (rem > HalfUlp) || ((rem == HalfUlp) && fl[0]);
      r   = fl + $signed(SumW'(up));
      if (r[SumW-1]) begin
         return '0;
      end else if (r > $signed(SumW'(255))) begin
         return '1;
      end else begin
         return r[CHAN_W-1:0];
      end
   endfunction

   // kernel geometry
   always_comb begin
      if (tap_count_ff == 4'd0) begin
         k_w = KW'(1);
      end else if (32'(tap_count_ff) > MAX_TAPS) begin
         k_w = KW'(MAX_TAPS);
      end else begin
         k_w = KW'(tap_count_ff);
      end
      half_w = k_w >> 1;
      maxr_w = k_w[0] ? half_w : half_w - KW'(1);
   end

   assign csr_ready = 1'b1;
   assign job_done  = !job_end_ff || (job_left_ff == CntW'(1));
   assign out_load  = job_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !job_valid_ff || (out_load && job_done);
   assign accept    = req_valid && req_ready;
   assign px_word   = {req_data.in_chan_three, req_data.in_chan_two,
                       req_data.in_chan_one, req_data.in_chan_zero};
   assign taps_flat = {tap_eight_ff, taps_hi_ff, taps_lo_ff};

   // window, line state and job load
   always_comb begin
      window_in        = window_ff;
      lookahead_in     = lookahead_ff;
      at_line_start_in = at_line_start_ff;
      look_new         = at_line_start_ff ? CntW'(1) : lookahead_ff + CntW'(1);
      emit_one         = BaseW'(look_new) > BaseW'(maxr_w);
      fill_win         = at_line_start_ff ? {MAX_TAPS{px_word}}
                                          : ((window_ff << PIXEL_W) | WinW'(px_word));
      if (req_data.in_line_end) begin
         base_w = BaseW'(look_new) - BaseW'(1) + BaseW'(half_w);
      end else begin
         base_w = BaseW'(maxr_w) + BaseW'(half_w);
      end
      if (32'(base_w) > MAX_TAPS - 1) begin
         shift_w = '0;
      end else begin
         shift_w = SftW'(BaseW'(MAX_TAPS - 1) - base_w);
      end
      if (accept) begin
         window_in        = fill_win;
         at_line_start_in = req_data.in_line_end;
         if (req_data.in_line_end) begin
            lookahead_in = '0;
         end else if (emit_one) begin
            lookahead_in = CntW'(maxr_w);
         end else begin
            lookahead_in = look_new;
         end
      end
   end

   always_comb begin
      job_valid_in = job_valid_ff;
      job_left_in  = job_left_ff;
      job_end_in   = job_end_ff;
      job_win_in   = job_win_ff;
      if (accept) begin
         job_valid_in = req_data.in_line_end || emit_one;
         job_left_in  = req_data.in_line_end ? look_new : CntW'(1);
         job_end_in   = req_data.in_line_end;
         job_win_in   = (fill_win << {shift_w, 5'd0})
                      | ({MAX_TAPS{fill_win[PIXEL_W-1:0]}}
                         & ~({WinW{1'b1}} << {shift_w, 5'd0}));
      end else if (out_load) begin
         if (job_done) begin
            job_valid_in = 1'b0;
         end else begin
            job_left_in = job_left_ff - CntW'(1);
            job_win_in  = (job_win_ff << PIXEL_W) | (job_win_ff & LowMask);
         end
      end
   end

   // filter datapath: tap j reads a fixed slot of the job window
   always_comb begin
      logic signed [SumW-1:0]  acc;
      logic [CHAN_W-1:0]       px;
      logic signed [ProdW-1:0] prod;
      for (int j = 0; j < MAX_TAPS; j++) begin
         tap_arr[j] = taps_flat[TAP_W*j +: TAP_W];
      end
      for (int c = 0; c < NUM_CHANS; c++) begin
         acc = '0;
         for (int j = 0; j < MAX_TAPS; j++) begin
            px   = job_win_ff[PIXEL_W*(MAX_TAPS-1-j) + CHAN_W*c +: CHAN_W];
            prod = ProdW'($signed(tap_arr[j]) * $signed({1'b0, px}));
            if (j < int'(k_w)) begin
               acc = acc + SumW'(prod);
            end
         end
         chan_res[c] = round_sat(acc);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (out_load) begin
         rsp_valid_in               = 1'b1;
         rsp_data_in.out_chan_zero  = chan_res[0];
         rsp_data_in.out_chan_one   = chan_res[1];
         rsp_data_in.out_chan_two   = chan_res[2];
         rsp_data_in.out_chan_three = chan_res[3];
         rsp_data_in.out_line_end   = job_end_ff && (job_left_ff == CntW'(1));
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff     <= 4'd1;
         taps_lo_ff       <= CSR_W'(4096);
         taps_hi_ff       <= '0;
         tap_eight_ff     <= '0;
         lookahead_ff     <= '0;
         at_line_start_ff <= 1'b1;
         job_valid_ff     <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_TAP_COUNT: tap_count_ff <= csr_data[3:0];
               CSR_TAPS_LO:   taps_lo_ff   <= csr_data;
               CSR_TAPS_HI:   taps_hi_ff   <= csr_data;
               CSR_TAP_EIGHT: tap_eight_ff <= csr_data[TAP_W-1:0];
               default: ;
            endcase
         end
         lookahead_ff     <= lookahead_in;
         at_line_start_ff <= at_line_start_in;
         job_valid_ff     <= job_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      window_ff   <= window_in;
      job_left_ff <= job_left_in;
      job_end_ff  <= job_end_in;
      job_win_ff  <= job_win_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_flush_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (job_valid_ff && job_end_ff && (job_left_ff > CntW'(1))) |-> !req_ready)
      else $error("req_ready high during a multi-result flush");

   a_job_count_live: assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (job_left_ff != '0))
      else $error("pending job with no results left");

   a_line_end_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.in_line_end) |=> (at_line_start_ff && (lookahead_ff == '0)))
      else $error("line end did not restart the line");

   a_job_retires: assert property (@(posedge clock) disable iff (reset)
      (out_load && job_done && !accept) |=> !job_valid_ff)
      else $error("finished job still pending");

endmodule

`default_nettype wire
